// ===== design/cldu_pkg.sv =====
package cldu_pkg;

	localparam int unsigned MAX_COLS = 40;
	localparam int unsigned COL_CNT_W = $clog2(MAX_COLS + 1);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic MODE_MSG = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		CMD_CURSOR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FAULT = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		JOB_MSG,
		JOB_FAULT,
		JOB_CLEAR
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [1:0] scr;
		logic [1:0] row;
		logic [7:0] ch;
		logic [COL_CNT_W-1:0] col;
		logic do_place;
		logic close;
	} job_t;

	typedef struct packed {
		cmd_t cmd;
		logic [1:0] scr;
		logic [4:0] col;
		logic [1:0] row;
		logic [7:0] ch;
	} result_t;

	typedef struct packed {
		logic emit;
		logic flush;
		result_t res;
	} os_req_t;

	typedef struct packed {
		logic init_done;
	} bk_status_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_EVT,
		B_SWEEP,
		B_RD,
		B_CMP,
		B_WR,
		B_END
	} bk_state_t;

endpackage

// ===== design/cldu_if.sv =====
interface cldu_item_if;
	logic valid;
	logic ready;
	logic mode;
	logic [1:0] screen_index;
	logic [1:0] row_index;
	logic [7:0] char_code;
	logic char_valid;
	logic last_of_message;
	logic link_ok;

	modport source (
		output valid, mode, screen_index, row_index, char_code, char_valid,
			last_of_message, link_ok,
		input ready
	);
	modport sink (
		input valid, mode, screen_index, row_index, char_code, char_valid,
			last_of_message, link_ok,
		output ready
	);
endinterface

interface cldu_result_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [1:0] target_screen;
	logic [4:0] cursor_column;
	logic [1:0] cursor_row;
	logic [7:0] out_char;
	logic last_result;

	modport source (
		output valid, command, target_screen, cursor_column, cursor_row, out_char,
			last_result,
		input ready
	);
	modport sink (
		input valid, command, target_screen, cursor_column, cursor_row, out_char,
			last_result,
		output ready
	);
endinterface

// ===== design/cldu_front.sv =====
module cldu_front #(
	parameter int unsigned SCREENS = 4,
	parameter int unsigned ROWS = 4,
	parameter int unsigned COLS = 20
) (
	input logic clk,
	input logic arst_n,
	cldu_item_if.sink item,
	input logic cfg_we,
	input logic [2:0] cfg_wdata,
	input cldu_pkg::bk_status_t status,
	output logic push,
	output cldu_pkg::job_t job,
	input logic full
);

	logic open_q;
	logic discard_q;
	logic [1:0] held_scr_q;
	logic [1:0] held_row_q;
	logic [cldu_pkg::COL_CNT_W-1:0] col_q;
	logic [SCREENS-1:0] failed_q;
	logic [2:0] count_q;

	int unsigned lim;
	logic scr_present;
	logic failed_hit;
	logic usable;
	logic first;
	logic bad_start;
	logic fault;
	logic eff_discard;
	logic [1:0] eff_scr;
	logic [1:0] eff_row;
	logic [cldu_pkg::COL_CNT_W-1:0] col_cur;
	logic do_place;
	logic push_c;
	logic accept;

	always_comb begin
		lim = (32'(count_q) < SCREENS) ? 32'(count_q) : SCREENS;
		scr_present = 32'(item.screen_index) < lim;
		failed_hit = 1'b0;
		for (int i = 0; i < SCREENS; i++) begin
			if (32'(item.screen_index) == i) begin
				failed_hit = failed_hit | failed_q[i];
			end
		end
		usable = scr_present && !failed_hit;
		first = !open_q;
		bad_start = !usable || (32'(item.row_index) >= ROWS);
		fault = (item.mode == cldu_pkg::MODE_MSG) && first && !bad_start && !item.link_ok;
		eff_discard = first ? (bad_start || !item.link_ok) : discard_q;
		eff_scr = first ? item.screen_index : held_scr_q;
		eff_row = first ? item.row_index : held_row_q;
		col_cur = first ? '0 : col_q;
		do_place = item.char_valid && (32'(col_cur) < COLS);
	end

	always_comb begin
		job.kind = cldu_pkg::JOB_MSG;
		job.scr = eff_scr;
		job.row = eff_row;
		job.ch = do_place ? item.char_code : cldu_pkg::SPACE_CHAR;
		job.col = col_cur;
		job.do_place = do_place;
		job.close = item.last_of_message;
		push_c = 1'b0;
		if (item.mode == cldu_pkg::MODE_CLEAR) begin
			job.kind = cldu_pkg::JOB_CLEAR;
			job.scr = item.screen_index;
			push_c = usable;
		end else if (fault) begin
			job.kind = cldu_pkg::JOB_FAULT;
			push_c = 1'b1;
		end else if (!eff_discard && (do_place || item.last_of_message)) begin
			push_c = 1'b1;
		end
	end

	assign item.ready = status.init_done && !full;
	assign accept = item.valid && item.ready;
	assign push = accept && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			discard_q <= 1'b0;
			held_scr_q <= '0;
			held_row_q <= '0;
			col_q <= '0;
			failed_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (accept && (item.mode == cldu_pkg::MODE_MSG)) begin
				if (item.last_of_message) begin
					open_q <= 1'b0;
					discard_q <= 1'b0;
					col_q <= '0;
				end else begin
					open_q <= 1'b1;
					discard_q <= eff_discard;
					col_q <= cldu_pkg::COL_CNT_W'(col_cur + cldu_pkg::COL_CNT_W'(do_place));
				end
				held_scr_q <= eff_scr;
				held_row_q <= eff_row;
				for (int i = 0; i < SCREENS; i++) begin
					if (fault && (32'(item.screen_index) == i)) begin
						failed_q[i] <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== design/cldu_queue.sv =====
module cldu_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cldu_pkg::job_t wdata,
	output logic full,
	input logic pop,
	output cldu_pkg::job_t rdata,
	output logic empty
);

	localparam int unsigned PTR_W = (cldu_pkg::QUEUE_DEPTH > 1) ?
		$clog2(cldu_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(cldu_pkg::QUEUE_DEPTH + 1);

	cldu_pkg::job_t slots_q [cldu_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (32'(count_q) == cldu_pkg::QUEUE_DEPTH);
	assign empty = (count_q == '0);
	assign rdata = slots_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (32'(wptr_q) == cldu_pkg::QUEUE_DEPTH - 1) ? '0 :
					PTR_W'(wptr_q + 1'b1);
			end
			if (do_pop) begin
				rptr_q <= (32'(rptr_q) == cldu_pkg::QUEUE_DEPTH - 1) ? '0 :
					PTR_W'(rptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== design/cldu_back.sv =====
module cldu_back #(
	parameter int unsigned SCREENS = 4,
	parameter int unsigned ROWS = 4,
	parameter int unsigned COLS = 20
) (
	input logic clk,
	input logic arst_n,
	input cldu_pkg::job_t job,
	input logic empty,
	output logic pop,
	output cldu_pkg::bk_status_t status,
	output cldu_pkg::os_req_t req,
	input logic os_ready
);

	localparam int unsigned DEPTH = SCREENS * ROWS * COLS;
	localparam int unsigned ROW_CELLS = ROWS * COLS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	cldu_pkg::bk_state_t st_q;
	cldu_pkg::bk_state_t st_nxt;
	cldu_pkg::job_t ent_q;
	logic [cldu_pkg::COL_CNT_W-1:0] col_q;
	logic [7:0] ch_q;
	logic cursor_q;
	logic [ADDR_W-1:0] swp_q;
	logic [ADDR_W-1:0] swp_end_q;

	logic [ADDR_W-1:0] addr_cur;
	logic [ADDR_W-1:0] base_scr;
	logic [ADDR_W-1:0] waddr;
	logic [7:0] wdata;
	logic mem_we;
	logic mem_re;
	logic diff;
	logic need_cur;
	logic need_wr;
	logic more;
	logic adv;
	cldu_pkg::result_t res_cur;
	cldu_pkg::result_t res_wr;
	cldu_pkg::result_t res_evt;

	always_comb begin
		addr_cur = ADDR_W'(32'(ent_q.scr) * ROW_CELLS + 32'(ent_q.row) * COLS + 32'(col_q));
		base_scr = ADDR_W'(32'(ent_q.scr) * ROW_CELLS);
		diff = (rdata_q != ch_q);
		need_cur = diff && !cursor_q;
		need_wr = diff || cursor_q;
		more = ent_q.close && (32'(col_q) + 1 < COLS);
		adv = ((st_q == cldu_pkg::B_CMP) && !need_cur && (!need_wr || os_ready)) ||
			((st_q == cldu_pkg::B_WR) && os_ready);

		res_cur.cmd = cldu_pkg::CMD_CURSOR;
		res_cur.scr = ent_q.scr;
		res_cur.col = 5'(col_q);
		res_cur.row = ent_q.row;
		res_cur.ch = '0;

		res_wr.cmd = cldu_pkg::CMD_WRITE;
		res_wr.scr = ent_q.scr;
		res_wr.col = 5'(col_q);
		res_wr.row = ent_q.row;
		res_wr.ch = ch_q;

		res_evt.scr = ent_q.scr;
		res_evt.col = '0;
		res_evt.ch = '0;
		if (ent_q.kind == cldu_pkg::JOB_CLEAR) begin
			res_evt.cmd = cldu_pkg::CMD_CLEAR;
			res_evt.row = '0;
		end else begin
			res_evt.cmd = cldu_pkg::CMD_FAULT;
			res_evt.row = ent_q.row;
		end
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			cldu_pkg::B_INIT: begin
				if (swp_q == swp_end_q) st_nxt = cldu_pkg::B_IDLE;
			end
			cldu_pkg::B_IDLE: begin
				if (!empty) begin
					if (job.kind == cldu_pkg::JOB_MSG) begin
						st_nxt = (job.do_place || (32'(job.col) < COLS)) ?
							cldu_pkg::B_RD : cldu_pkg::B_END;
					end else begin
						st_nxt = cldu_pkg::B_EVT;
					end
				end
			end
			cldu_pkg::B_EVT: begin
				if (os_ready) begin
					st_nxt = (ent_q.kind == cldu_pkg::JOB_CLEAR) ?
						cldu_pkg::B_SWEEP : cldu_pkg::B_END;
				end
			end
			cldu_pkg::B_SWEEP: begin
				if (swp_q == swp_end_q) st_nxt = cldu_pkg::B_END;
			end
			cldu_pkg::B_RD: begin
				st_nxt = cldu_pkg::B_CMP;
			end
			cldu_pkg::B_CMP: begin
				if (need_cur) begin
					if (os_ready) st_nxt = cldu_pkg::B_WR;
				end else if (adv) begin
					st_nxt = more ? cldu_pkg::B_RD : cldu_pkg::B_END;
				end
			end
			cldu_pkg::B_WR: begin
				if (adv) st_nxt = more ? cldu_pkg::B_RD : cldu_pkg::B_END;
			end
			cldu_pkg::B_END: begin
				if (os_ready) st_nxt = cldu_pkg::B_IDLE;
			end
			default: begin
				st_nxt = cldu_pkg::B_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		pop = 1'b0;
		req = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr = addr_cur;
		wdata = ch_q;
		case (st_q)
			cldu_pkg::B_INIT, cldu_pkg::B_SWEEP: begin
				mem_we = 1'b1;
				waddr = swp_q;
				wdata = cldu_pkg::SPACE_CHAR;
			end
			cldu_pkg::B_IDLE: begin
				pop = !empty;
			end
			cldu_pkg::B_EVT: begin
				req.emit = 1'b1;
				req.res = res_evt;
			end
			cldu_pkg::B_RD: begin
				mem_re = 1'b1;
			end
			cldu_pkg::B_CMP: begin
				mem_we = diff;
				if (need_cur) begin
					req.emit = 1'b1;
					req.res = res_cur;
				end else if (need_wr) begin
					req.emit = 1'b1;
					req.res = res_wr;
				end
			end
			cldu_pkg::B_WR: begin
				mem_we = 1'b1;
				req.emit = 1'b1;
				req.res = res_wr;
			end
			cldu_pkg::B_END: begin
				req.flush = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign status.init_done = (st_q != cldu_pkg::B_INIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cldu_pkg::B_INIT;
			cursor_q <= 1'b0;
			swp_q <= '0;
			swp_end_q <= ADDR_W'(DEPTH - 1);
		end else begin
			st_q <= st_nxt;
			if ((st_q == cldu_pkg::B_INIT) || (st_q == cldu_pkg::B_SWEEP)) begin
				swp_q <= ADDR_W'(swp_q + 1'b1);
			end
			if ((st_q == cldu_pkg::B_EVT) && os_ready) begin
				swp_q <= base_scr;
				swp_end_q <= ADDR_W'(32'(base_scr) + ROW_CELLS - 1);
			end
			if ((st_q == cldu_pkg::B_CMP) && need_cur && os_ready) begin
				cursor_q <= 1'b1;
			end
			if ((st_q == cldu_pkg::B_END) && os_ready &&
				(ent_q.kind == cldu_pkg::JOB_MSG) && ent_q.close) begin
				cursor_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= job;
			col_q <= job.col;
			ch_q <= job.ch;
		end else if (adv) begin
			col_q <= cldu_pkg::COL_CNT_W'(col_q + 1'b1);
			ch_q <= cldu_pkg::SPACE_CHAR;
		end
	end

	// shadow store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[addr_cur];
		end
	end

endmodule

// ===== design/cldu_out_stage.sv =====
module cldu_out_stage (
	input logic clk,
	input logic arst_n,
	input cldu_pkg::os_req_t req,
	output logic os_ready,
	cldu_result_if.source result
);

	logic pend_v_q;
	cldu_pkg::result_t pend_q;
	logic out_v_q;
	cldu_pkg::result_t out_q;
	logic out_last_q;
	logic take_emit;
	logic take_flush;

	// one result is held back until it is known whether another follows
	assign os_ready = !pend_v_q || !out_v_q || result.ready;
	assign take_emit = req.emit && os_ready;
	assign take_flush = req.flush && os_ready && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			if (take_emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
			end else if (take_flush) begin
				pend_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_emit) begin
			pend_q <= req.res;
			if (pend_v_q) begin
				out_q <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (take_flush) begin
			out_q <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid = out_v_q;
	assign result.command = out_q.cmd;
	assign result.target_screen = out_q.scr;
	assign result.cursor_column = out_q.col;
	assign result.cursor_row = out_q.row;
	assign result.out_char = out_q.ch;
	assign result.last_result = out_last_q;

endmodule

// ===== design/char_lcd_row_diff_updater_unit.sv =====
// a result passes the job queue, the back-end states and the out stage; the
// final result of a transaction waits in a hold register until the next one or the end.
// flow: the queue takes transactions while the back end works on earlier ones, unless full;
// a placed column's shadow cell is read and compared, a set-cursor going first if needed;
// a last transaction blanks the columns left; a clear blanks its screen's ROWS*COLS cells.
// reset: async, active low; then all SCREENS*ROWS*COLS shadow cells are filled with spaces.
module char_lcd_row_diff_updater_unit #(
	parameter int unsigned SCREENS = 4,
	parameter int unsigned ROWS = 4,
	parameter int unsigned COLS = 20
) (
	input logic clk,
	input logic arst_n,
	cldu_item_if.sink item,
	cldu_result_if.source result,
	input logic cfg_we,
	input logic [2:0] cfg_wdata
);

	cldu_pkg::bk_status_t status;
	cldu_pkg::job_t push_job;
	cldu_pkg::job_t head_job;
	cldu_pkg::os_req_t os_req;
	logic push;
	logic full;
	logic pop;
	logic empty;
	logic os_ready;

	cldu_front #(
		.SCREENS(SCREENS),
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.status(status),
		.push(push),
		.job(push_job),
		.full(full)
	);

	cldu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_job),
		.full(full),
		.pop(pop),
		.rdata(head_job),
		.empty(empty)
	);

	cldu_back #(
		.SCREENS(SCREENS),
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(head_job),
		.empty(empty),
		.pop(pop),
		.status(status),
		.req(os_req),
		.os_ready(os_ready)
	);

	cldu_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.req(os_req),
		.os_ready(os_ready),
		.result(result)
	);

endmodule

// ===== design/cldu_checker.sv =====
module cldu_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_command,
	input logic [1:0] out_screen,
	input logic [4:0] out_column,
	input logic [1:0] out_row,
	input logic [7:0] out_char,
	input logic out_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_command, out_screen, out_column, out_row, out_char, out_last}))
		else $error("result changed while stalled");

	a_event_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_command == cldu_pkg::CMD_FAULT ||
			out_command == cldu_pkg::CMD_CLEAR) |-> out_last)
		else $error("fault or clear not the only result of its transaction");

	a_cursor_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_command == cldu_pkg::CMD_CURSOR |-> !out_last)
		else $error("set cursor closes a transaction");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_command != cldu_pkg::CMD_WRITE |-> out_char == 8'h00)
		else $error("character on a non-write result");

endmodule

bind char_lcd_row_diff_updater_unit cldu_checker u_cldu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_command(result.command),
	.out_screen(result.target_screen),
	.out_column(result.cursor_column),
	.out_row(result.cursor_row),
	.out_char(result.out_char),
	.out_last(result.last_result)
);
